// ===== hw/rtl/fpq_pkg.sv =====
`default_nettype none
package fpq_pkg;

	localparam int FRAME_W     = 32;
	localparam int TIME_W      = 48;
	localparam int AVG_W       = 56;
	localparam int BLEND_W     = 17;
	localparam int FRAC_BITS   = 8;
	localparam int DEPTH       = 4;
	localparam int PTR_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int DIV_W       = 64;
	localparam int BLEND_STEPS = 16;
	localparam int AVG_STEPS   = 7;
	localparam int STEP_W      = $clog2(BLEND_STEPS + 1);
	localparam int REM_W       = 5;

	localparam logic [AVG_W-1:0]   AVG_MAX      = '1;
	localparam logic [AVG_W-1:0]   PERIOD_RESET = AVG_W'(4266667);
	localparam logic [BLEND_W-1:0] BLEND_ONE    = BLEND_W'(65536);

	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_POP     = 2'd1,
		CMD_PRESENT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAP,
		ST_PREP,
		ST_BLOAD,
		ST_BDIV,
		ST_SUM,
		ST_ADIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic calc_gap;
		logic calc_prep;
		logic load_blend;
		logic div_step;
		logic avg_step;
		logic sum;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic blend_needed;
		logic avg_needed;
		logic div_last;
		logic out_taken;
	} ctl_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fpq_if.sv =====
`default_nettype none
interface fpq_in_if import fpq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [FRAME_W-1:0] frame_number;
	logic [TIME_W-1:0]  decode_time;
	logic [TIME_W-1:0]  target_time;
	logic [TIME_W-1:0]  observed_time;

	modport source (output valid, command, frame_number, decode_time, target_time,
		observed_time, input ready);
	modport sink (input valid, command, frame_number, decode_time, target_time,
		observed_time, output ready);
endinterface

interface fpq_out_if import fpq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               frame_valid;
	logic [FRAME_W-1:0] out_frame_number;
	logic [TIME_W-1:0]  out_decode_time;
	logic [TIME_W-1:0]  out_target_time;
	logic [BLEND_W-1:0] out_blend;
	logic [CNT_W-1:0]   fill_level;
	logic               dropped;
	logic [AVG_W-1:0]   mean_decode_gap;
	logic [AVG_W-1:0]   mean_jitter;
	logic [AVG_W-1:0]   period_estimate;

	modport source (output valid, frame_valid, out_frame_number, out_decode_time,
		out_target_time, out_blend, fill_level, dropped, mean_decode_gap, mean_jitter,
		period_estimate, input ready);
	modport sink (input valid, frame_valid, out_frame_number, out_decode_time,
		out_target_time, out_blend, fill_level, dropped, mean_decode_gap, mean_jitter,
		period_estimate, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fpq_ctrl.sv =====
`default_nettype none
module fpq_ctrl import fpq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire ctl_status_t status,
	output ctl_cmd_t         cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_GAP;
			end
			ST_GAP:   state_nxt = ST_PREP;
			ST_PREP:  state_nxt = ST_BLOAD;
			ST_BLOAD: state_nxt = status.blend_needed ? ST_BDIV : ST_SUM;
			ST_BDIV: begin
				if (status.div_last) state_nxt = ST_SUM;
			end
			ST_SUM:   state_nxt = status.avg_needed ? ST_ADIV : ST_OUT;
			ST_ADIV: begin
				if (status.div_last) state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_taken) state_nxt = ST_IDLE;
			end
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// The commit pulse is issued on the way into the output state; the result
	// register then holds until the item is taken.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			ST_GAP:   cmd.calc_gap = 1'b1;
			ST_PREP:  cmd.calc_prep = 1'b1;
			ST_BLOAD: cmd.load_blend = status.blend_needed;
			ST_BDIV:  cmd.div_step = 1'b1;
			ST_SUM: begin
				cmd.sum = 1'b1;
				cmd.commit = !status.avg_needed;
			end
			ST_ADIV: begin
				cmd.avg_step = 1'b1;
				cmd.commit = status.div_last;
			end
			ST_OUT: ;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/fpq_datapath.sv =====
`default_nettype none
module fpq_datapath import fpq_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctl_cmd_t           cmd,
	output ctl_status_t             status,
	input  wire logic [1:0]         in_command,
	input  wire logic [FRAME_W-1:0] in_frame_number,
	input  wire logic [TIME_W-1:0]  in_decode_time,
	input  wire logic [TIME_W-1:0]  in_target_time,
	input  wire logic [TIME_W-1:0]  in_observed_time,
	fpq_out_if.source               out_ch
);

	typedef struct packed {
		logic [FRAME_W-1:0] frame_number;
		logic [TIME_W-1:0]  decode_time;
		logic [TIME_W-1:0]  target_time;
		logic [BLEND_W-1:0] blend;
	} entry_t;

	function automatic logic [AVG_W-1:0] to_q8(input logic [TIME_W-1:0] us);
		logic [TIME_W+FRAC_BITS-1:0] wide;
		wide = {us, FRAC_BITS'(0)};
		if (us > TIME_W'(AVG_MAX >> FRAC_BITS)) return AVG_MAX;
		return AVG_W'(wide);
	endfunction

	function automatic logic [TIME_W-1:0] gap_of(input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] prev);
		return (now > prev) ? now - prev : '0;
	endfunction

	entry_t mem [DEPTH];
	entry_t rd_q;

	cmd_t               cmd_q;
	logic [FRAME_W-1:0] frame_q;
	logic [TIME_W-1:0]  dec_q, tgt_q, obs_q;
	logic [TIME_W-1:0]  bgap_q, agap_q;
	logic [AVG_W-1:0]   x_q;
	logic               blend_needed_q, avg_needed_q;
	logic [BLEND_W-1:0] blend_w_q;

	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [TIME_W-1:0]  last_dec_q, last_pres_q;
	logic [AVG_W-1:0]   dec_avg_q, jit_avg_q, period_q;
	logic               out_valid_q;

	logic [AVG_W-1:0]       rem_q;
	logic [BLEND_STEPS-1:0] quo_q;
	logic [DIV_W-1:0]       n_q, est_q;
	logic [REM_W-1:0]       r_q;
	logic [STEP_W-1:0]      div_cnt_q;

	logic [PTR_W-1:0]   rd_addr, wr_addr;
	logic [PTR_W-1:0]   head_after;
	logic [CNT_W-1:0]   count_after;
	logic               drop_w, valid_w;
	logic [AVG_W:0]     trial;
	logic               trial_ge;
	logic [AVG_W-1:0]   avg_sel, avg_res, bq8, g8, x_w;
	logic [DIV_W-1:0]   sum_w, q_fin;
	logic               is_present;

	assign rd_addr = (cmd_t'(in_command) == CMD_PUSH)
		? PTR_W'(CNT_W'(head_q) + count_q - CNT_W'(1)) : head_q;
	assign wr_addr = PTR_W'(CNT_W'(head_q) + count_q);

	always_ff @(posedge clk) begin
		if (cmd.commit && cmd_q == CMD_PUSH) begin
			mem[wr_addr] <= '{frame_number: frame_q, decode_time: dec_q,
				target_time: tgt_q, blend: blend_w_q};
		end
		if (cmd.capture) rd_q <= mem[rd_addr];
	end

	// Restoring divider for the blend weight, one quotient bit per step.
	assign trial    = {rem_q, 1'b0};
	assign trial_ge = trial >= {1'b0, period_q};

	assign bq8 = to_q8(bgap_q);
	assign g8  = to_q8(agap_q);
	assign x_w = (cmd_q == CMD_POP)
		? ((g8 > period_q) ? g8 - period_q : period_q - g8) : g8;

	assign is_present = (cmd_q == CMD_PRESENT);
	always_comb begin
		case (cmd_q)
			CMD_POP:     avg_sel = jit_avg_q;
			CMD_PRESENT: avg_sel = period_q;
			default:     avg_sel = dec_avg_q;
		endcase
	end
	// 19*avg + x + 10 for the period, 9*avg + x + 5 otherwise.
	assign sum_w = is_present
		? (DIV_W'(avg_sel) << 4) + (DIV_W'(avg_sel) << 1) + DIV_W'(avg_sel)
			+ DIV_W'(x_q) + DIV_W'(10)
		: (DIV_W'(avg_sel) << 3) + DIV_W'(avg_sel) + DIV_W'(x_q) + DIV_W'(5);

	// The estimate of n/10 is never high and at most one low, which the
	// remainder check corrects.
	assign q_fin   = est_q + DIV_W'(r_q > REM_W'(9));
	assign avg_res = (q_fin > DIV_W'(AVG_MAX)) ? AVG_MAX : AVG_W'(q_fin);

	always_comb begin
		head_after  = head_q;
		count_after = count_q;
		drop_w      = 1'b0;
		valid_w     = 1'b0;
		case (cmd_q)
			CMD_PUSH: begin
				if (count_q == CNT_W'(DEPTH)) begin
					head_after = head_q + PTR_W'(1);
					drop_w     = 1'b1;
				end else begin
					count_after = count_q + CNT_W'(1);
				end
			end
			CMD_POP: begin
				if (count_q != '0) begin
					valid_w     = 1'b1;
					head_after  = head_q + PTR_W'(1);
					count_after = count_q - CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			last_dec_q  <= '0;
			last_pres_q <= '0;
			dec_avg_q   <= '0;
			jit_avg_q   <= '0;
			period_q    <= PERIOD_RESET;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			if (cmd.load_blend) div_cnt_q <= STEP_W'(BLEND_STEPS);
			else if (cmd.sum && avg_needed_q) div_cnt_q <= STEP_W'(AVG_STEPS);
			else if ((cmd.div_step || cmd.avg_step) && div_cnt_q != '0)
				div_cnt_q <= div_cnt_q - STEP_W'(1);

			if (cmd.commit) begin
				head_q      <= head_after;
				count_q     <= count_after;
				out_valid_q <= 1'b1;
				case (cmd_q)
					CMD_PUSH: begin
						last_dec_q <= dec_q;
						if (avg_needed_q) dec_avg_q <= avg_res;
					end
					CMD_POP: begin
						if (count_q != '0) last_pres_q <= rd_q.target_time;
						if (avg_needed_q) jit_avg_q <= avg_res;
					end
					CMD_PRESENT: begin
						if (avg_needed_q) period_q <= avg_res;
					end
					default: ;
				endcase
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	logic               o_frame_valid_q, o_dropped_q;
	logic [FRAME_W-1:0] o_frame_q;
	logic [TIME_W-1:0]  o_dec_q, o_tgt_q;
	logic [BLEND_W-1:0] o_blend_q;
	logic [CNT_W-1:0]   o_fill_q;
	logic [AVG_W-1:0]   o_dec_avg_q, o_jit_q, o_period_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= cmd_t'(in_command);
			frame_q <= in_frame_number;
			dec_q   <= in_decode_time;
			tgt_q   <= in_target_time;
			obs_q   <= in_observed_time;
		end
		if (cmd.calc_gap) begin
			bgap_q <= gap_of(tgt_q, rd_q.target_time);
			case (cmd_q)
				CMD_POP:     agap_q <= gap_of(rd_q.target_time, last_pres_q);
				CMD_PRESENT: agap_q <= gap_of(obs_q, last_pres_q);
				default:     agap_q <= gap_of(dec_q, last_dec_q);
			endcase
		end
		if (cmd.calc_prep) begin
			x_q       <= x_w;
			blend_w_q <= BLEND_ONE;
			blend_needed_q <= (cmd_q == CMD_PUSH) && (count_q != '0)
				&& (period_q != '0) && (bq8 < period_q);
			case (cmd_q)
				CMD_PUSH:    avg_needed_q <= (last_dec_q != '0);
				CMD_POP:     avg_needed_q <= (count_q != '0) && (last_pres_q != '0);
				CMD_PRESENT: avg_needed_q <= (last_pres_q != '0) && (obs_q > last_pres_q);
				default:     avg_needed_q <= 1'b0;
			endcase
		end
		if (cmd.load_blend) begin
			rem_q <= bq8;
			quo_q <= '0;
		end else if (cmd.sum) begin
			if (blend_needed_q) blend_w_q <= {1'b0, quo_q};
			// A division by 20 is a halving followed by a division by 10.
			n_q <= is_present ? (sum_w >> 1) : sum_w;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? AVG_W'(trial - {1'b0, period_q}) : AVG_W'(trial);
			quo_q <= {quo_q[BLEND_STEPS-2:0], trial_ge};
		end
		// Division by 10 as a multiply by 0.8 built from shifts and adds,
		// one term per cycle, then a shift by three and a remainder check.
		if (cmd.avg_step) begin
			case (div_cnt_q)
				STEP_W'(AVG_STEPS):     est_q <= (n_q >> 1) + (n_q >> 2);
				STEP_W'(AVG_STEPS - 1): est_q <= est_q + (est_q >> 4);
				STEP_W'(AVG_STEPS - 2): est_q <= est_q + (est_q >> 8);
				STEP_W'(AVG_STEPS - 3): est_q <= est_q + (est_q >> 16);
				STEP_W'(AVG_STEPS - 4): est_q <= (est_q + (est_q >> 32)) >> 3;
				STEP_W'(AVG_STEPS - 5):
					r_q <= REM_W'(n_q - ((est_q << 3) + (est_q << 1)));
				default: ;
			endcase
		end
		if (cmd.commit) begin
			o_frame_valid_q <= valid_w;
			o_frame_q       <= valid_w ? rd_q.frame_number : '0;
			o_dec_q         <= valid_w ? rd_q.decode_time : '0;
			o_tgt_q         <= valid_w ? rd_q.target_time : '0;
			o_blend_q       <= valid_w ? rd_q.blend : '0;
			o_fill_q        <= count_after;
			o_dropped_q     <= drop_w;
			o_dec_avg_q     <= (cmd_q == CMD_PUSH && avg_needed_q) ? avg_res : dec_avg_q;
			o_jit_q         <= (cmd_q == CMD_POP && avg_needed_q) ? avg_res : jit_avg_q;
			o_period_q      <= (is_present && avg_needed_q) ? avg_res : period_q;
		end
	end

	assign status = '{blend_needed: blend_needed_q, avg_needed: avg_needed_q,
		div_last: (div_cnt_q == STEP_W'(1)), out_taken: (out_valid_q && out_ch.ready)};

	assign out_ch.valid            = out_valid_q;
	assign out_ch.frame_valid      = o_frame_valid_q;
	assign out_ch.out_frame_number = o_frame_q;
	assign out_ch.out_decode_time  = o_dec_q;
	assign out_ch.out_target_time  = o_tgt_q;
	assign out_ch.out_blend        = o_blend_q;
	assign out_ch.fill_level       = o_fill_q;
	assign out_ch.dropped          = o_dropped_q;
	assign out_ch.mean_decode_gap  = o_dec_avg_q;
	assign out_ch.mean_jitter      = o_jit_q;
	assign out_ch.period_estimate  = o_period_q;

endmodule
`default_nettype wire

// ===== hw/rtl/frame_pacing_queue_top.sv =====
`default_nettype none
// Four-entry frame timing queue that drops its oldest entry on overflow and keeps
// running averages of decode interval, present jitter and display period (Q8
// microseconds). Items are handled one at a time; before its result is valid, a
// push may compute a blend weight and a push, pop or present may update one
// average. The blend weight comes from a restoring divider that produces one
// quotient bit per cycle (16 steps); an average uses shift-and-add division by
// ten. The next item is accepted in the cycle after the result has been taken.
module frame_pacing_queue_top import fpq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	fpq_in_if.sink    in_ch,
	fpq_out_if.source out_ch
);

	ctl_cmd_t    ctl_cmd;
	ctl_status_t ctl_status;
	logic        ctl_ready;

	assign in_ch.ready = ctl_ready;

	fpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (ctl_ready),
		.status   (ctl_status),
		.cmd      (ctl_cmd)
	);

	fpq_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (ctl_cmd),
		.status           (ctl_status),
		.in_command       (in_ch.command),
		.in_frame_number  (in_ch.frame_number),
		.in_decode_time   (in_ch.decode_time),
		.in_target_time   (in_ch.target_time),
		.in_observed_time (in_ch.observed_time),
		.out_ch           (out_ch)
	);

	// Only one item is in flight, so input and output are never open together.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input ready while a result is pending");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.fill_level <= CNT_W'(DEPTH))
		else $error("fill level above queue depth");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.dropped) |-> (out_ch.fill_level == CNT_W'(DEPTH)
			&& !out_ch.frame_valid))
		else $error("drop reported without a full queue");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input still ready after accepting an item");

endmodule
`default_nettype wire

// ===== tb/fpq_tb_if.sv =====
// The block's interfaces fpq_in_if and fpq_out_if are declared with the RTL.
// This file only carries the command and status record types that the bench uses.
package fpq_tb_pkg;
	import fpq_pkg::*;

	typedef struct packed {
		cmd_t               command;
		logic [FRAME_W-1:0] frame_number;
		logic [TIME_W-1:0]  decode_time;
		logic [TIME_W-1:0]  target_time;
		logic [TIME_W-1:0]  observed_time;
	} frame_cmd_t;

	typedef struct packed {
		logic               frame_valid;
		logic [FRAME_W-1:0] frame_number;
		logic [TIME_W-1:0]  decode_time;
		logic [TIME_W-1:0]  target_time;
		logic [BLEND_W-1:0] blend;
		logic [CNT_W-1:0]   fill_level;
		logic               dropped;
		logic [AVG_W-1:0]   mean_decode_gap;
		logic [AVG_W-1:0]   mean_jitter;
		logic [AVG_W-1:0]   period_estimate;
	} frame_status_t;
endpackage

// ===== tb/tb_frame_pacing_queue_top.sv =====
`default_nettype none
module tb_frame_pacing_queue_top;
	import fpq_pkg::*;
	import fpq_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fpq_in_if  in_ch ();
	fpq_out_if out_ch ();

	frame_pacing_queue_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #6 clk = ~clk;

	// Predicted queue and averages.
	logic [FRAME_W-1:0] q_frame [DEPTH];
	logic [TIME_W-1:0]  q_decode [DEPTH];
	logic [TIME_W-1:0]  q_target [DEPTH];
	logic [BLEND_W-1:0] q_blend [DEPTH];
	int unsigned        q_head;
	int unsigned        q_count;
	logic [TIME_W-1:0]  last_decode;
	logic [TIME_W-1:0]  last_present;
	logic [AVG_W-1:0]   decode_avg;
	logic [AVG_W-1:0]   jitter_avg;
	logic [AVG_W-1:0]   period_avg;

	frame_status_t expected_status [$];
	int            error_count = 0;
	int            stall_hold = 0;
	bit            sender_busy = 1'b0;
	logic [TIME_W-1:0] now_us;

	function automatic logic [TIME_W-1:0] time_gap(logic [TIME_W-1:0] later,
			logic [TIME_W-1:0] earlier);
		return (later > earlier) ? later - earlier : '0;
	endfunction

	function automatic logic [AVG_W-1:0] us_to_q8(logic [TIME_W-1:0] us);
		if (us > (AVG_MAX >> FRAC_BITS))
			return AVG_MAX;
		return AVG_W'(us) << FRAC_BITS;
	endfunction

	function automatic logic [AVG_W-1:0] ewma(logic [AVG_W-1:0] avg,
			logic [AVG_W-1:0] x, int keep, int div);
		logic [71:0] acc;
		acc = (72'(keep) * avg + x + 72'(div / 2)) / 72'(div);
		return (acc > AVG_MAX) ? AVG_MAX : acc[AVG_W-1:0];
	endfunction

	function automatic logic [BLEND_W-1:0] blend_of(logic [TIME_W-1:0] gap);
		logic [63:0] rem;
		logic [BLEND_W-1:0] quo;
		if (period_avg == 0 || gap > (AVG_MAX >> FRAC_BITS))
			return BLEND_ONE;
		rem = 64'(gap) << FRAC_BITS;
		if (rem >= period_avg)
			return BLEND_ONE;
		quo = '0;
		for (int i = 0; i < BLEND_STEPS; i++) begin
			rem = rem << 1;
			quo = quo << 1;
			if (rem >= period_avg) begin
				rem -= period_avg;
				quo[0] = 1'b1;
			end
		end
		return quo;
	endfunction

	task automatic reset_prediction();
		q_head = 0;
		q_count = 0;
		last_decode = '0;
		last_present = '0;
		decode_avg = '0;
		jitter_avg = '0;
		period_avg = PERIOD_RESET;
	endtask

	function automatic frame_status_t advance_queue(frame_cmd_t c);
		frame_status_t s;
		int unsigned pos;
		logic [AVG_W-1:0] g, j;
		s = '0;
		case (c.command)
			CMD_PUSH: begin
				s.blend = BLEND_ONE;
				if (q_count > 0)
					s.blend = blend_of(time_gap(c.target_time,
						q_target[(q_head + q_count - 1) % DEPTH]));
				if (last_decode != 0)
					decode_avg = ewma(decode_avg,
						us_to_q8(time_gap(c.decode_time, last_decode)), 9, 10);
				last_decode = c.decode_time;
				pos = (q_head + q_count) % DEPTH;
				q_frame[pos] = c.frame_number;
				q_decode[pos] = c.decode_time;
				q_target[pos] = c.target_time;
				q_blend[pos] = s.blend;
				s.blend = '0;
				if (q_count >= DEPTH) begin
					q_head = (q_head + 1) % DEPTH;
					s.dropped = 1'b1;
				end else begin
					q_count++;
				end
			end
			CMD_POP: begin
				if (q_count > 0) begin
					s.frame_valid = 1'b1;
					s.frame_number = q_frame[q_head];
					s.decode_time = q_decode[q_head];
					s.target_time = q_target[q_head];
					s.blend = q_blend[q_head];
					q_head = (q_head + 1) % DEPTH;
					q_count--;
					if (last_present != 0) begin
						g = us_to_q8(time_gap(s.target_time, last_present));
						j = (g > period_avg) ? g - period_avg : period_avg - g;
						jitter_avg = ewma(jitter_avg, j, 9, 10);
					end
					last_present = s.target_time;
				end
			end
			CMD_PRESENT: begin
				if (last_present != 0 && c.observed_time > last_present)
					period_avg = ewma(period_avg,
						us_to_q8(c.observed_time - last_present), 19, 20);
			end
			default: ;
		endcase
		s.fill_level = CNT_W'(q_count);
		s.mean_decode_gap = decode_avg;
		s.mean_jitter = jitter_avg;
		s.period_estimate = period_avg;
		return s;
	endfunction

	task automatic report_mismatch(string what, logic [AVG_W-1:0] got,
			logic [AVG_W-1:0] want);
		$display("MISMATCH %s: got %0h, expected %0h", what, got, want);
		error_count++;
	endtask

	task automatic send_item(frame_cmd_t c);
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.command <= c.command;
		in_ch.frame_number <= c.frame_number;
		in_ch.decode_time <= c.decode_time;
		in_ch.target_time <= c.target_time;
		in_ch.observed_time <= c.observed_time;
		do @(posedge clk); while (!in_ch.ready);
		expected_status.insert(expected_status.size(), advance_queue(c));
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// Bursts of back-to-back items separated by random gaps.
	task automatic send_burst(frame_cmd_t c);
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 12)) @(negedge clk);
		send_item(c);
	endtask

	task automatic wait_drained();
		while (expected_status.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic frame_cmd_t make_cmd(cmd_t op, logic [FRAME_W-1:0] fn,
			logic [TIME_W-1:0] dec, logic [TIME_W-1:0] tgt, logic [TIME_W-1:0] obs);
		frame_cmd_t c;
		c.command = op;
		c.frame_number = fn;
		c.decode_time = dec;
		c.target_time = tgt;
		c.observed_time = obs;
		return c;
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// Checker.
	always @(posedge clk) begin
		frame_status_t got, want;
		if (out_ch.valid && out_ch.ready) begin
			got.frame_valid = out_ch.frame_valid;
			got.frame_number = out_ch.out_frame_number;
			got.decode_time = out_ch.out_decode_time;
			got.target_time = out_ch.out_target_time;
			got.blend = out_ch.out_blend;
			got.fill_level = out_ch.fill_level;
			got.dropped = out_ch.dropped;
			got.mean_decode_gap = out_ch.mean_decode_gap;
			got.mean_jitter = out_ch.mean_jitter;
			got.period_estimate = out_ch.period_estimate;
			if (expected_status.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				want = expected_status[0];
				expected_status.delete(0);
				if (got.frame_valid !== want.frame_valid)
					report_mismatch("frame_valid", got.frame_valid, want.frame_valid);
				if (got.frame_number !== want.frame_number)
					report_mismatch("frame_number", got.frame_number, want.frame_number);
				if (got.decode_time !== want.decode_time)
					report_mismatch("decode_time", got.decode_time, want.decode_time);
				if (got.target_time !== want.target_time)
					report_mismatch("target_time", got.target_time, want.target_time);
				if (got.blend !== want.blend)
					report_mismatch("blend", got.blend, want.blend);
				if (got.fill_level !== want.fill_level)
					report_mismatch("fill_level", got.fill_level, want.fill_level);
				if (got.dropped !== want.dropped)
					report_mismatch("dropped", got.dropped, want.dropped);
				if (got.mean_decode_gap !== want.mean_decode_gap)
					report_mismatch("mean_decode_gap", got.mean_decode_gap,
						want.mean_decode_gap);
				if (got.mean_jitter !== want.mean_jitter)
					report_mismatch("mean_jitter", got.mean_jitter, want.mean_jitter);
				if (got.period_estimate !== want.period_estimate)
					report_mismatch("period_estimate", got.period_estimate,
						want.period_estimate);
			end
		end
	end

	// Receiver stall pattern, with a long hold-off when a test sets stall_hold.
	always @(negedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic test_directed();
		logic [TIME_W-1:0] tmax;
		tmax = '1;
		send_item(make_cmd(CMD_POP, 0, 0, 0, 0));
		send_item(make_cmd(CMD_PRESENT, 0, 0, 0, 5000));
		send_item(make_cmd(CMD_NONE, 32'hFFFF_FFFF, tmax, tmax, tmax));
		send_item(make_cmd(CMD_PUSH, 0, 0, 0, 0));
		send_item(make_cmd(CMD_PUSH, 32'hFFFF_FFFF, 1000, 8000, 0));
		send_item(make_cmd(CMD_PUSH, 2, 500, 4000, 0));
		send_item(make_cmd(CMD_PUSH, 3, 17000, 30000, 0));
		send_item(make_cmd(CMD_PUSH, 4, tmax, tmax, 0));
		send_item(make_cmd(CMD_PUSH, 5, 1, 1, 0));
		send_item(make_cmd(CMD_POP, 0, 0, 0, 0));
		send_item(make_cmd(CMD_POP, 0, 0, 0, 0));
		send_item(make_cmd(CMD_PRESENT, 0, 0, 0, tmax));
		send_item(make_cmd(CMD_PRESENT, 0, 0, 0, 1));
		send_item(make_cmd(CMD_POP, 0, 0, 0, 0));
		send_item(make_cmd(CMD_POP, 0, 0, 0, 0));
		send_item(make_cmd(CMD_POP, 0, 0, 0, 0));
		send_item(make_cmd(CMD_PUSH, 6, 2000, 100, 0));
		send_item(make_cmd(CMD_PUSH, 7, 3000, tmax - 5, 0));
		send_item(make_cmd(CMD_PUSH, 8, tmax, 0, 0));
		send_item(make_cmd(CMD_POP, 0, 0, 0, 0));
		send_item(make_cmd(CMD_POP, 0, 0, 0, 0));
		send_item(make_cmd(CMD_POP, 0, 0, 0, 0));
		wait_drained();
	endtask

	// Realistic pacing: times advance by around one display period.
	task automatic test_paced_stream(int count);
		frame_cmd_t c;
		int unsigned sel;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 9);
			now_us += $urandom_range(8000, 25000);
			if (sel < 5)
				c = make_cmd(CMD_PUSH, $urandom, now_us,
					now_us + $urandom_range(0, 40000), 0);
			else if (sel < 8)
				c = make_cmd(CMD_POP, $urandom, rand_time(), rand_time(), 0);
			else
				c = make_cmd(CMD_PRESENT, 0, 0, 0, now_us + $urandom_range(0, 30000));
			send_burst(c);
		end
	endtask

	// Noise: arbitrary fields and commands, including the unused one.
	task automatic test_random_fields(int count);
		for (int i = 0; i < count; i++)
			send_burst(make_cmd(cmd_t'($urandom_range(0, 3)), $urandom, rand_time(),
				rand_time(), rand_time()));
	endtask

	task automatic test_long_stall();
		stall_hold = 400;
		test_paced_stream(12);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = CMD_NONE;
		in_ch.frame_number = '0;
		in_ch.decode_time = '0;
		in_ch.target_time = '0;
		in_ch.observed_time = '0;
		out_ch.ready = 1'b0;
		now_us = 48'd1_000_000;
		reset_prediction();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_paced_stream(250);
		test_long_stall();
		wait_drained();
		test_random_fields(120);
		now_us = 48'hFFFF_FFF0_0000;
		test_paced_stream(60);
		now_us = 48'd50_000;
		test_paced_stream(100);
		wait_drained();

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
